// ===== sv/mprc_pkg.sv =====
// ----------------------------------------------------------------------------
// mprc_pkg
// Shared types and constants for the Modbus poll response checker: the item
// that travels from the classifier to the frame checker, status codes and
// protocol constants.
// ----------------------------------------------------------------------------
package mprc_pkg;

    // Modbus function code for "read holding registers".
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    // Value reported for temperature and humidity of a rejected frame (-100).
    localparam logic [15:0] REJECT_VALUE      = 16'hFF9C;
    // CRC-16/Modbus start value and reflected polynomial.
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    // Reset value of the slave count register and the first polled address.
    localparam logic [7:0]  SLAVE_COUNT_RESET = 8'd20;
    localparam logic [7:0]  FIRST_ADDRESS     = 8'd1;

    // Queue between classifier and checker; depth must be a power of two.
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_VALID    = 3'd0,
        ST_NO_REPLY = 3'd1,
        ST_BAD_CRC  = 3'd2,
        ST_BAD_FUNC = 3'd3,
        ST_BAD_ADDR = 3'd4
    } t_status;

    // Role of a reply byte, taken from its position in the frame.
    typedef enum logic [2:0] {
        SLOT_NONE,
        SLOT_ADDR,
        SLOT_FUNC,
        SLOT_TEMP_HI,
        SLOT_TEMP_LO,
        SLOT_HUM_HI,
        SLOT_HUM_LO
    } t_slot;

    // Length class of a frame, attached to its frame-end item.
    typedef enum logic [1:0] {
        LEN_EMPTY,
        LEN_SHORT,
        LEN_OK
    } t_len;

    // One classified item.
    typedef struct packed {
        logic       is_end;
        t_slot      slot;
        t_len       len;
        logic [7:0] data;
    } t_item;

endpackage

// ===== sv/mprc_front.sv =====
// ----------------------------------------------------------------------------
// mprc_front
// Accepts input items and classifies them: each reply byte gets its role in
// the frame, each frame end gets the length class of the frame it closes.
// ----------------------------------------------------------------------------
module mprc_front
    import mprc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic [7:0] i_rx_byte,
    output logic       o_push,
    output t_item      o_item,
    input  logic       i_full
);

    // Byte position in the current frame, saturating; only 0 to 10 matter.
    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic       w_accept;

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && !i_full;
    assign o_push     = w_accept;

    // Classification of the current item.
    always_comb begin
        o_item.is_end = i_kind;
        o_item.data   = i_rx_byte;
        case (r_pos)
            4'd0:    o_item.slot = SLOT_ADDR;
            4'd1:    o_item.slot = SLOT_FUNC;
            4'd3:    o_item.slot = SLOT_TEMP_HI;
            4'd4:    o_item.slot = SLOT_TEMP_LO;
            4'd9:    o_item.slot = SLOT_HUM_HI;
            4'd10:   o_item.slot = SLOT_HUM_LO;
            default: o_item.slot = SLOT_NONE;
        endcase
        case (r_pos)
            4'd0:    o_item.len = LEN_EMPTY;
            4'd1:    o_item.len = LEN_SHORT;
            default: o_item.len = LEN_OK;
        endcase
    end

    // Position counter: restarts on frame end, saturates on long frames.
    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            if (i_kind) begin
                n_pos = '0;
            end else if (r_pos != '1) begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== sv/mprc_queue.sv =====
// ----------------------------------------------------------------------------
// mprc_queue
// Small first-in first-out queue of classified items between the classifier
// and the frame checker.
// ----------------------------------------------------------------------------
module mprc_queue
    import mprc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam logic [QUEUE_AW:0] FULL_FILL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    t_item                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_AW:0]    r_fill;
    logic [QUEUE_AW:0]    n_fill;
    logic                 w_do_pop;

    assign o_full   = (r_fill == FULL_FILL);
    assign o_valid  = (r_fill != '0);
    assign o_item   = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    // Fill level follows pushes and pops.
    always_comb begin
        n_fill = r_fill;
        case ({i_push, w_do_pop})
            2'b10:   n_fill = r_fill + 1'b1;
            2'b01:   n_fill = r_fill - 1'b1;
            default: n_fill = r_fill;
        endcase
    end

    // Storage, written at the write pointer.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_fill <= n_fill;
        end
    end

endmodule

// ===== sv/mprc_back.sv =====
// ----------------------------------------------------------------------------
// mprc_back
// Frame checker: runs the CRC-16 over each reply byte, latches the address,
// function and data words, and on frame end judges the frame, loads the
// result register and moves on to the next polled address.
// ----------------------------------------------------------------------------
module mprc_back
    import mprc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_slave_count,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_slave_address,
    output logic signed [15:0] o_temperature,
    output logic signed [15:0] o_humidity,
    output logic [2:0]         o_status
);

    // Byte-wide CRC-16/Modbus update, one bit per step.
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    logic [7:0]  r_poll_addr;
    logic [15:0] r_crc;
    logic [7:0]  r_addr_byte;
    logic [7:0]  r_func_byte;
    logic [15:0] r_temp;
    logic [15:0] r_hum;
    logic        r_out_valid;
    logic [7:0]  r_out_addr;
    logic [15:0] r_out_temp;
    logic [15:0] r_out_hum;
    t_status     r_out_status;

    logic        w_end;
    logic        w_byte;
    t_status     w_status;
    logic [15:0] w_temp;
    logic [15:0] w_hum;
    logic [7:0]  w_next_addr;

    // A byte always moves on; a frame end needs room in the result register.
    assign o_pop  = i_valid && (!i_item.is_end || !r_out_valid || i_out_ready);
    assign w_end  = o_pop && i_item.is_end;
    assign w_byte = o_pop && !i_item.is_end;

    // Frame judgment: length, then CRC, then function, then address.
    always_comb begin
        w_temp = REJECT_VALUE;
        w_hum  = REJECT_VALUE;
        if (i_item.len == LEN_EMPTY) begin
            w_status = ST_NO_REPLY;
            w_temp   = '0;
            w_hum    = '0;
        end else if (i_item.len == LEN_SHORT || r_crc != '0) begin
            w_status = ST_BAD_CRC;
        end else if (r_func_byte != FUNC_READ_HOLDING) begin
            w_status = ST_BAD_FUNC;
        end else if (r_addr_byte != r_poll_addr) begin
            w_status = ST_BAD_ADDR;
        end else begin
            w_status = ST_VALID;
            w_temp   = r_temp;
            w_hum    = r_hum;
        end
    end

    // Rotation through the slave addresses.
    assign w_next_addr = (r_poll_addr >= i_slave_count) ? FIRST_ADDRESS
                                                        : r_poll_addr + 8'd1;

    // Frame state and poll address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_addr <= FIRST_ADDRESS;
            r_crc       <= CRC_INIT;
            r_addr_byte <= '0;
            r_func_byte <= '0;
            r_temp      <= '0;
            r_hum       <= '0;
        end else if (w_end) begin
            r_poll_addr <= w_next_addr;
            r_crc       <= CRC_INIT;
            r_addr_byte <= '0;
            r_func_byte <= '0;
            r_temp      <= '0;
            r_hum       <= '0;
        end else if (w_byte) begin
            r_crc <= crc_update(r_crc, i_item.data);
            case (i_item.slot)
                SLOT_ADDR:    r_addr_byte  <= i_item.data;
                SLOT_FUNC:    r_func_byte  <= i_item.data;
                SLOT_TEMP_HI: r_temp[15:8] <= i_item.data;
                SLOT_TEMP_LO: r_temp[7:0]  <= i_item.data;
                SLOT_HUM_HI:  r_hum[15:8]  <= i_item.data;
                SLOT_HUM_LO:  r_hum[7:0]   <= i_item.data;
                default:      ;
            endcase
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_out_addr   <= r_poll_addr;
            r_out_temp   <= w_temp;
            r_out_hum    <= w_hum;
            r_out_status <= w_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_slave_address = r_out_addr;
    assign o_temperature   = r_out_temp;
    assign o_humidity      = r_out_hum;
    assign o_status        = r_out_status;

endmodule

// ===== sv/modbus_poll_response_checker_core.sv =====
// ----------------------------------------------------------------------------
// modbus_poll_response_checker_core
// Checks Modbus RTU read replies from slaves polled in rotation and reports
// temperature, humidity and a status for each reply frame.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_ready   i_kind, i_rx_byte
//   result    out        o_out_valid / i_out_ready o_slave_address,
//                                                  o_temperature, o_humidity,
//                                                  o_status
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_data (slave count)
//
// One item per cycle is accepted while the queue has room; the rate is set by the byte-wide CRC
// update in the frame checker, which takes one byte each cycle.
// A frame-end item is written into the queue when it is accepted, and loads the
// result register once it reaches the head of the queue and the result register
// has room; the result register then drives the result port.
// Reset is synchronous and active low; the slave count returns to 20 and
// polling restarts at address 1.
// A stalled result directly holds back only frame-end items; reply bytes keep
// flowing through the four-entry queue until a frame end reaches its head.
// ----------------------------------------------------------------------------
module modbus_poll_response_checker_core
    import mprc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_slave_address,
    output logic signed [15:0] o_temperature,
    output logic signed [15:0] o_humidity,
    output logic [2:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    logic [7:0] r_count;
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_q_valid;
    t_item      w_push_item;
    t_item      w_head_item;

    // Slave count register; always ready for a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= SLAVE_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    // Classifier.
    mprc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_rx_byte  (i_rx_byte),
        .o_push     (w_push),
        .o_item     (w_push_item),
        .i_full     (w_full)
    );

    // Item queue.
    mprc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_head_item)
    );

    // Frame checker and result register.
    mprc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slave_count   (r_count),
        .i_valid         (w_q_valid),
        .i_item          (w_head_item),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_slave_address (o_slave_address),
        .o_temperature   (o_temperature),
        .o_humidity      (o_humidity),
        .o_status        (o_status)
    );

endmodule

// ===== sv/mprc_checker.sv =====
// ----------------------------------------------------------------------------
// mprc_checker
// Port-level checks of the poll response checker, attached to the top level
// by a bind statement.
// ----------------------------------------------------------------------------
module mprc_checker
    import mprc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [7:0]         o_slave_address,
    input  logic signed [15:0] o_temperature,
    input  logic signed [15:0] o_humidity,
    input  logic [2:0]         o_status
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_slave_address) && $stable(o_status)
            && $stable(o_temperature) && $stable(o_humidity))
        else $error("result changed while stalled");

    // Polled addresses start at one.
    a_addr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_slave_address != 8'd0)
        else $error("result for address zero");

    // No reply reports zero readings.
    a_no_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NO_REPLY |->
            o_temperature == 16'sd0 && o_humidity == 16'sd0)
        else $error("no-reply result carries readings");

    // A rejected frame reports the reject value in both readings.
    a_reject_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_BAD_CRC || o_status == ST_BAD_FUNC
            || o_status == ST_BAD_ADDR) |->
            o_temperature == REJECT_VALUE && o_humidity == REJECT_VALUE)
        else $error("rejected frame without reject value");

endmodule

bind modbus_poll_response_checker_core mprc_checker u_mprc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_slave_address (o_slave_address),
    .o_temperature   (o_temperature),
    .o_humidity      (o_humidity),
    .o_status        (o_status)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Modbus poll response checker. Reply frames are
// built from random content with a correct CRC, or deliberately damaged, and
// are fed byte by byte with frame-end markers. An in-bench model of the frame
// check predicts each reading, which is compared with every result
// transaction. Both channels idle at random, and the result side is stalled
// for long stretches so that the block fills up. The slave count is changed
// between phases, covering its extremes and a value below the polled address.
// ----------------------------------------------------------------------------
module tb_top
    import mprc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Item kinds on the input channel.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Byte positions inside a reply frame.
    localparam logic [7:0] POS_ADDR    = 8'd0;
    localparam logic [7:0] POS_FUNC    = 8'd1;
    localparam logic [7:0] POS_TEMP_HI = 8'd3;
    localparam logic [7:0] POS_TEMP_LO = 8'd4;
    localparam logic [7:0] POS_HUM_HI  = 8'd9;
    localparam logic [7:0] POS_HUM_LO  = 8'd10;
    localparam logic [7:0] LEN_SATURATED = 8'd255;

    localparam int ITEM_TARGET  = 1900;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    // Longest correct stretch without any transaction is a receiver hold plus
    // a gap, a drain pause and a configuration write; this is several times that.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        SHAPE_VALID,
        SHAPE_BAD_CRC,
        SHAPE_BAD_FUNC,
        SHAPE_BAD_ADDR,
        SHAPE_EMPTY,
        SHAPE_ONE_BYTE,
        SHAPE_NOISE,
        SHAPE_LONG
    } t_frame_shape;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_link_item;

    typedef struct packed {
        logic [7:0]  addr;
        logic [15:0] temp;
        logic [15:0] hum;
        t_status     status;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_kind = KIND_BYTE;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [7:0]         o_slave_address;
    logic signed [15:0] o_temperature;
    logic signed [15:0] o_humidity;
    logic [2:0]         o_status;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_data = 8'h00;

    // Model state of the frame check, at reset values.
    logic [7:0]  slave_count_cfg = SLAVE_COUNT_RESET;
    logic [7:0]  poll_addr = FIRST_ADDRESS;
    logic [15:0] frame_crc = CRC_INIT;
    logic [7:0]  frame_len = 8'd0;
    logic [7:0]  hdr_addr = 8'd0;
    logic [7:0]  hdr_func = 8'd0;
    logic [15:0] temp_word = 16'd0;
    logic [15:0] hum_word = 16'd0;

    t_link_item link_items[$];
    t_reading   awaited_readings[$];
    logic [7:0] planned_poll = FIRST_ADDRESS;

    int items_queued = 0;
    int items_sent = 0;
    int readings_checked = 0;
    int failures = 0;
    int settings_used = 0;
    int in_gap = 0;
    int in_calm = 0;
    int out_gap = 0;
    int out_calm = 0;
    int hold_left = 0;
    int hold_mark = -1;
    int idle_cycles = 0;

    modbus_poll_response_checker_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_slave_address (o_slave_address),
        .o_temperature   (o_temperature),
        .o_humidity      (o_humidity),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Byte-wise CRC-16 update, reflected polynomial.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Rotation of the polled address, wrapping at the slave count.
    function automatic logic [7:0] next_poll_address(input logic [7:0] a);
        return (a >= slave_count_cfg) ? FIRST_ADDRESS : a + 8'd1;
    endfunction

    // Idle cycles before the next transaction; calm stretches have none.
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // Frame check model: bytes update the frame state, a frame end yields a reading.
    function automatic void track_link_item(input logic kind, input logic [7:0] b);
        t_reading r;
        if (kind == KIND_BYTE) begin
            frame_crc = crc16_step(frame_crc, b);
            case (frame_len)
                POS_ADDR:    hdr_addr = b;
                POS_FUNC:    hdr_func = b;
                POS_TEMP_HI: temp_word[15:8] = b;
                POS_TEMP_LO: temp_word[7:0] = b;
                POS_HUM_HI:  hum_word[15:8] = b;
                POS_HUM_LO:  hum_word[7:0] = b;
                default: ;
            endcase
            if (frame_len != LEN_SATURATED) frame_len = frame_len + 8'd1;
        end else begin
            r.addr = poll_addr;
            r.temp = REJECT_VALUE;
            r.hum = REJECT_VALUE;
            if (frame_len == 8'd0) begin
                r.status = ST_NO_REPLY;
                r.temp = 16'd0;
                r.hum = 16'd0;
            end else if (frame_len < 8'd2 || frame_crc != 16'd0) begin
                r.status = ST_BAD_CRC;
            end else if (hdr_func != FUNC_READ_HOLDING) begin
                r.status = ST_BAD_FUNC;
            end else if (hdr_addr != poll_addr) begin
                r.status = ST_BAD_ADDR;
            end else begin
                r.status = ST_VALID;
                r.temp = temp_word;
                r.hum = hum_word;
            end
            awaited_readings.push_back(r);
            poll_addr = next_poll_address(poll_addr);
            frame_crc = CRC_INIT;
            frame_len = 8'd0;
            hdr_addr = 8'd0;
            hdr_func = 8'd0;
            temp_word = 16'd0;
            hum_word = 16'd0;
        end
    endfunction

    task automatic note_failure(input string what);
        failures++;
        if (failures <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, what);
    endtask

    task automatic queue_item(input logic kind, input logic [7:0] b);
        link_items.push_back('{kind, b});
        items_queued++;
    endtask

    // Queues a frame body, optionally with its CRC and one flipped bit, then the end.
    task automatic send_frame(input logic [7:0] body[$], input bit add_crc, input int flip);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (body[i]) crc = crc16_step(crc, body[i]);
        if (add_crc) begin
            body.push_back(crc[7:0]);
            body.push_back(crc[15:8]);
        end
        if (flip >= 0) body[flip / 8] = body[flip / 8] ^ (8'h01 << (flip % 8));
        foreach (body[i]) queue_item(KIND_BYTE, body[i]);
        queue_item(KIND_END, 8'($urandom));
        planned_poll = next_poll_address(planned_poll);
    endtask

    // Builds a reply of the given shape for the address that will be polled.
    task automatic queue_frame(input t_frame_shape shape);
        logic [7:0] body[$];
        logic [7:0] v;
        int n;
        case (shape)
            SHAPE_EMPTY: send_frame(body, 1'b0, -1);
            SHAPE_ONE_BYTE: begin
                body.push_back(8'($urandom));
                send_frame(body, 1'b0, -1);
            end
            SHAPE_NOISE: begin
                n = $urandom_range(2, 12);
                repeat (n) body.push_back(8'($urandom));
                send_frame(body, 1'b0, -1);
            end
            default: begin
                n = (shape == SHAPE_LONG) ? $urandom_range(253, 290) : $urandom_range(0, 20);
                body.push_back(planned_poll);
                body.push_back(FUNC_READ_HOLDING);
                body.push_back(8'(n));
                repeat (n) body.push_back(8'($urandom));
                if (shape == SHAPE_BAD_FUNC) begin
                    do v = 8'($urandom); while (v == FUNC_READ_HOLDING);
                    body[1] = v;
                end
                if (shape == SHAPE_BAD_ADDR) begin
                    do v = 8'($urandom); while (v == planned_poll);
                    body[0] = v;
                end
                send_frame(body, 1'b1,
                           (shape == SHAPE_BAD_CRC) ? $urandom_range(0, (n + 5) * 8 - 1) : -1);
            end
        endcase
    endtask

    // Mostly well-formed replies, the rest damaged or missing.
    function automatic t_frame_shape pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58) return SHAPE_VALID;
        if (r < 66) return SHAPE_BAD_CRC;
        if (r < 73) return SHAPE_BAD_FUNC;
        if (r < 80) return SHAPE_BAD_ADDR;
        if (r < 86) return SHAPE_EMPTY;
        if (r < 92) return SHAPE_ONE_BYTE;
        return SHAPE_NOISE;
    endfunction

    task automatic write_slave_count(input logic [7:0] count);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= count;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        slave_count_cfg = count;
        settings_used++;
    endtask

    // Waits until every queued item is taken and every reading has arrived.
    task automatic wait_drained();
        while (items_sent != items_queued || awaited_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Input driver: presents queued items with random gaps between transactions.
    always @(posedge i_clk) begin
        t_link_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (i_in_valid && o_in_ready === 1'b1) begin
                track_link_item(i_kind, i_rx_byte);
                items_sent <= items_sent + 1;
            end
            if (!i_in_valid || o_in_ready === 1'b1) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (link_items.size() != 0) begin
                    nxt = link_items.pop_front();
                    i_kind <= nxt.kind;
                    i_rx_byte <= nxt.data;
                    i_in_valid <= 1'b1;
                    in_gap <= draw_gap(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transaction against the oldest predicted reading.
    always @(posedge i_clk) begin
        int gap_n;
        t_reading e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap <= 0;
        end else begin
            gap_n = (out_gap > 0) ? out_gap - 1 : 0;
            if (o_out_valid === 1'b1 && i_out_ready) begin
                readings_checked <= readings_checked + 1;
                if (awaited_readings.size() == 0) begin
                    note_failure($sformatf("unexpected reading for slave %0d", o_slave_address));
                end else begin
                    e = awaited_readings.pop_front();
                    if (o_slave_address !== e.addr || o_temperature !== e.temp ||
                        o_humidity !== e.hum || o_status !== e.status) begin
                        note_failure($sformatf(
                            "reading mismatch: expected addr %0d temp %0d hum %0d status %0d, got addr %0d temp %0d hum %0d status %0d",
                            e.addr, $signed(e.temp), $signed(e.hum), e.status,
                            o_slave_address, o_temperature, o_humidity, o_status));
                    end
                end
                gap_n = draw_gap(out_calm);
            end
            out_gap <= gap_n;
            i_out_ready <= (gap_n == 0) && (hold_left == 0);
        end
    end

    // Long receiver stalls at two points of the run, so that the block backs up.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (readings_checked != hold_mark &&
                     (readings_checked == 25 || readings_checked == 200)) begin
            hold_left <= HOLD_CYCLES;
            hold_mark <= readings_checked;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a transaction", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus phases.
    initial begin
        logic [7:0] body[$];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no reply, one byte, extreme words, header-only reply, then bad CRC, function and address.
        queue_frame(SHAPE_EMPTY);
        queue_frame(SHAPE_ONE_BYTE);
        body = '{planned_poll, FUNC_READ_HOLDING, 8'd8, 8'h7F, 8'hFF, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h80, 8'h00};
        send_frame(body, 1'b1, -1);
        body = '{planned_poll, FUNC_READ_HOLDING};
        send_frame(body, 1'b1, -1);
        queue_frame(SHAPE_BAD_CRC);
        queue_frame(SHAPE_BAD_FUNC);
        queue_frame(SHAPE_BAD_ADDR);
        // A reply longer than the byte counter can hold.
        queue_frame(SHAPE_LONG);
        repeat (20) queue_frame(pick_shape());
        wait_drained();

        // A single slave: the address settles at one and then never moves.
        write_slave_count(8'd1);
        repeat (15) queue_frame(pick_shape());
        wait_drained();

        // Largest rotation, walked through mostly with missing replies.
        write_slave_count(8'd247);
        repeat (250) queue_frame(($urandom_range(0, 9) == 0) ? pick_shape() : SHAPE_EMPTY);
        wait_drained();

        write_slave_count(8'd30);
        repeat (14) queue_frame(pick_shape());
        wait_drained();

        // Count lowered below the address being polled.
        write_slave_count(8'd3);
        repeat (10) queue_frame(pick_shape());
        wait_drained();

        // A count of zero keeps the rotation at the first address.
        write_slave_count(8'd0);
        repeat (8) queue_frame(pick_shape());
        wait_drained();

        while (items_queued < ITEM_TARGET) begin
            write_slave_count(8'($urandom_range(1, 247)));
            repeat (20) queue_frame(pick_shape());
            wait_drained();
        end

        $display("Checked %0d readings from %0d link items under %0d slave-count settings,",
                 readings_checked, items_sent, settings_used + 1);
        $display("covering valid, empty, short, corrupted, misaddressed and oversized replies.");
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d failures", failures);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
